FILE: rtl/jarp_pkg.sv
package jarp_pkg;

  localparam int unsigned WORD_COUNT = 17;
  localparam int unsigned KIND_W     = 5;
  localparam int unsigned IDX_W      = 5;

  localparam logic [IDX_W-1:0] KEY_LEN   = 5'd6;
  localparam logic [IDX_W-1:0] KEY_MAX   = 5'd15;
  localparam logic [IDX_W-1:0] VALUE_MAX = 5'd31;

  localparam logic [WORD_COUNT-1:0] ALL_WORDS = 17'h1FFFF;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // String constants are right-justified: the first character sits in the highest used byte.
  localparam logic [47:0] KEY_TEXT = "action";

  localparam logic [119:0] WORD_TEXT [WORD_COUNT] = '{
    "ping", "status", "subscribe", "hardware", "cpu", "gpu", "memory",
    "disks", "pci", "usb", "network", "interfaces", "ethernet", "drivers",
    {"drivers_", "missing"}, "firmware", "diagnose"
  };

  localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
    4'd4, 4'd6, 4'd9, 4'd8, 4'd3, 4'd3, 4'd6, 4'd5, 4'd3, 4'd3, 4'd7, 4'd10,
    4'd8, 4'd7, 4'd15, 4'd8, 4'd8
  };

  function automatic logic is_blank(logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic bad_string_byte(logic [7:0] b);
    return (b < CH_SPACE) || (b == CH_BSLASH);
  endfunction

  function automatic logic key_char_ok(logic [IDX_W-1:0] idx, logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    if (idx >= KEY_LEN) begin
      return 1'b0;
    end
    pos = 3'd5 - idx[2:0];
    return KEY_TEXT[{pos, 3'b000} +: 8] == b;
  endfunction

  function automatic logic word_char_ok(int unsigned w, logic [IDX_W-1:0] idx,
                                        logic [7:0] b);
    logic [3:0] pos;
    pos = 4'd0;
    if (idx >= {1'b0, WORD_LEN[w]}) begin
      return 1'b0;
    end
    pos = WORD_LEN[w] - 4'd1 - idx[3:0];
    return WORD_TEXT[w][{pos, 3'b000} +: 8] == b;
  endfunction

endpackage

FILE: rtl/json_action_request_parser.sv
// Checks a request payload of the form { "action" : "word" } one byte per word.
// Slave channel: s_axis_tdata_i carries one payload byte, s_axis_tlast_i marks the
// last byte of the payload. Master channel: one word per payload, sent after the
// last byte, with the accepted flag and the command number (0 when not accepted).
// A byte is registered in the input register when it is accepted and parsed when the
// parser takes it from there, so the result word of a payload is registered in the
// result register when the parser takes its last byte.
// The block takes one byte every cycle unless a last byte waits on a pending
// result; the two registers decouple the sides, so bytes flow while a result waits.
// When the receiver stalls a pending result, the next last byte waits in the input
// register and the slave side stops until the pending result word is taken.
// Reset clears the parser to expect an opening brace and empties both registers.
// After each last byte the parser returns to that same state by itself.
// Payloads longer than MAX_MESSAGE bytes are rejected.
module json_action_request_parser #(
  parameter int unsigned MAX_MESSAGE = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] payload_byte
  input  logic       s_axis_tlast_i,   // final_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] accepted, [5:1] request_kind, [7:6] zero
);

  import jarp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_MESSAGE + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MESSAGE);

  typedef enum logic [2:0] {
    PH_OPEN, PH_KEY_QUOTE, PH_KEY, PH_COLON,
    PH_VALUE_QUOTE, PH_VALUE, PH_CLOSE, PH_TAIL
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  key_ok_q, key_ok_d;
  logic [WORD_COUNT-1:0] cand_q, cand_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  err_q, err_d;

  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic                  in_last_q;
  logic                  out_valid_q;
  logic                  out_acc_q;
  logic [KIND_W-1:0]     out_kind_q;

  logic                  adv;
  logic                  take;
  logic [KIND_W-1:0]     kind;
  logic [7:0]            b;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign take            = in_valid_q && (adv || !in_last_q);
  assign s_axis_tready_o = !in_valid_q || take;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_kind_q, out_acc_q};
  assign b               = in_byte_q;

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    key_ok_d = key_ok_q;
    cand_d   = cand_q;
    cnt_d    = cnt_q;
    err_d    = err_q;
    kind     = '0;

    if (cnt_q <= CNT_MAX) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (cnt_d > CNT_MAX) begin
      err_d = 1'b1;
    end

    if (!err_d) begin
      unique case (phase_q)
        PH_OPEN: begin
          if (!is_blank(b)) begin
            if (b == CH_LBRACE) phase_d = PH_KEY_QUOTE;
            else err_d = 1'b1;
          end
        end
        PH_KEY_QUOTE: begin
          if (!is_blank(b)) begin
            if (b == CH_QUOTE) begin
              phase_d  = PH_KEY;
              idx_d    = '0;
              key_ok_d = 1'b1;
            end else begin
              err_d = 1'b1;
            end
          end
        end
        PH_KEY: begin
          if (b == CH_QUOTE) begin
            if (!key_ok_q || (idx_q != KEY_LEN)) err_d = 1'b1;
            else phase_d = PH_COLON;
            idx_d = '0;
          end else if (bad_string_byte(b) || (idx_q >= KEY_MAX)) begin
            err_d = 1'b1;
          end else begin
            if (!key_char_ok(idx_q, b)) key_ok_d = 1'b0;
            idx_d = idx_q + IDX_W'(1);
          end
        end
        PH_COLON: begin
          if (!is_blank(b)) begin
            if (b == CH_COLON) phase_d = PH_VALUE_QUOTE;
            else err_d = 1'b1;
          end
        end
        PH_VALUE_QUOTE: begin
          if (!is_blank(b)) begin
            if (b == CH_QUOTE) begin
              phase_d = PH_VALUE;
              idx_d   = '0;
              cand_d  = ALL_WORDS;
            end else begin
              err_d = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          if (b == CH_QUOTE) begin
            for (int w = 0; w < WORD_COUNT; w++) begin
              if ({1'b0, WORD_LEN[w]} != idx_q) cand_d[w] = 1'b0;
            end
            phase_d = PH_CLOSE;
          end else if (bad_string_byte(b) || (idx_q >= VALUE_MAX)) begin
            err_d = 1'b1;
          end else begin
            for (int w = 0; w < WORD_COUNT; w++) begin
              if (!word_char_ok(w, idx_q, b)) cand_d[w] = 1'b0;
            end
            idx_d = idx_q + IDX_W'(1);
          end
        end
        PH_CLOSE: begin
          if (!is_blank(b)) begin
            if (b == CH_RBRACE) phase_d = PH_TAIL;
            else err_d = 1'b1;
          end
        end
        PH_TAIL: begin
          if (!is_blank(b)) err_d = 1'b1;
        end
      endcase
    end

    if (!err_d && (phase_d == PH_TAIL)) begin
      for (int w = WORD_COUNT - 1; w >= 0; w--) begin
        if (cand_d[w]) kind = KIND_W'(w + 1);
      end
    end

    if (in_last_q) begin
      phase_d  = PH_OPEN;
      idx_d    = '0;
      key_ok_d = 1'b1;
      cand_d   = ALL_WORDS;
      cnt_d    = '0;
      err_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_OPEN;
      idx_q       <= '0;
      key_ok_q    <= 1'b1;
      cand_q      <= ALL_WORDS;
      cnt_q       <= '0;
      err_q       <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (take) begin
        phase_q  <= phase_d;
        idx_q    <= idx_d;
        key_ok_q <= key_ok_d;
        cand_q   <= cand_d;
        cnt_q    <= cnt_d;
        err_q    <= err_d;
      end
      if (take && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (take && in_last_q) begin
      out_acc_q  <= (kind != '0);
      out_kind_q <= kind;
    end
  end

`ifndef SYNTH
  a_acc_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_acc_q == (out_kind_q != '0)))
    else $error("accepted flag disagrees with the command number");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_kind_q <= KIND_W'(WORD_COUNT)))
    else $error("command number out of range");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_last_q) |=> ((phase_q == PH_OPEN) && (cnt_q == '0) && !err_q))
    else $error("parser did not restart after the last byte");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX + CNT_W'(1))
    else $error("byte count passed its saturation value");

  a_result_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !(take && in_last_q)) |=> !out_valid_q)
    else $error("result word raised without a last byte");
`endif

endmodule
